[sv/lbnd_pkg.sv]
// lbnd_pkg: opcodes, reset constants, powers of ten and the microcode ROM
// for the LED blink-number display. No dependencies.

package lbnd_pkg;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_START   = 2'd1,
		OP_ENABLE  = 2'd2,
		OP_DISABLE = 2'd3
	} opcode_t;

	localparam logic [15:0] SLOT_TICKS_RST = 16'd200;
	localparam logic [6:0]  ZERO_LEN       = 7'd12;
	localparam logic [6:0]  TAIL_SLOTS     = 7'd12;
	localparam logic [6:0]  ZERO_LIT_SLOTS = 7'd5;
	localparam logic [6:0]  MAX_LEN        = 7'd66;
	localparam logic [3:0]  MAX_EXP        = 4'd9;

	// which power of ten the compare/subtract unit sees
	typedef enum logic [1:0] {
		PS_KP1 = 2'd0,
		PS_K   = 2'd1,
		PS_KM1 = 2'd2
	} psel_t;

	typedef enum logic [1:0] {
		COND_GE      = 2'd0,
		COND_GE_KLT9 = 2'd1,
		COND_GE_KNZ  = 2'd2,
		COND_NEVER   = 2'd3
	} cond_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_INC_K = 2'd1,
		ACT_CNT_W = 2'd2,
		ACT_CNT_D = 2'd3
	} act_t;

	typedef logic [1:0] step_t;

	localparam step_t STEP_EXP  = 2'd0;
	localparam step_t STEP_LEAD = 2'd1;
	localparam step_t STEP_SEC  = 2'd2;
	localparam step_t STEP_FIN  = 2'd3;

	typedef struct packed {
		psel_t psel;
		cond_t cond;
		act_t  act;
		step_t t_next;
		step_t f_next;
		logic  fin;
	} uword_t;

	function automatic uword_t ucode(input step_t pc);
		uword_t w;
		unique case (pc)
			STEP_EXP:  w = '{PS_KP1, COND_GE_KLT9, ACT_INC_K, STEP_EXP,  STEP_LEAD, 1'b0};
			STEP_LEAD: w = '{PS_K,   COND_GE,      ACT_CNT_W, STEP_LEAD, STEP_SEC,  1'b0};
			STEP_SEC:  w = '{PS_KM1, COND_GE_KNZ,  ACT_CNT_D, STEP_SEC,  STEP_FIN,  1'b0};
			STEP_FIN:  w = '{PS_K,   COND_NEVER,   ACT_NONE,  STEP_EXP,  STEP_EXP,  1'b1};
			default:   w = '{PS_K,   COND_NEVER,   ACT_NONE,  STEP_EXP,  STEP_EXP,  1'b1};
		endcase
		return w;
	endfunction

	function automatic logic [31:0] pow10(input logic [3:0] idx);
		logic [31:0] p;
		case (idx)
			4'd0:    p = 32'd1;
			4'd1:    p = 32'd10;
			4'd2:    p = 32'd100;
			4'd3:    p = 32'd1000;
			4'd4:    p = 32'd10000;
			4'd5:    p = 32'd100000;
			4'd6:    p = 32'd1000000;
			4'd7:    p = 32'd10000000;
			4'd8:    p = 32'd100000000;
			4'd9:    p = 32'd1000000000;
			default: p = 32'hFFFF_FFFF;
		endcase
		return p;
	endfunction

endpackage

[sv/lbnd_cmd_if.sv]
// lbnd_cmd_if: command channel (valid/ready) of the blink-number display.
// Depends on nothing.

interface lbnd_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] value;
	logic        once_flag;

	modport source (output valid, opcode, value, once_flag, input ready);
	modport sink   (input valid, opcode, value, once_flag, output ready);
endinterface

[sv/lbnd_rsp_if.sv]
// lbnd_rsp_if: response channel (valid/ready) of the blink-number display.
// Depends on nothing.

interface lbnd_rsp_if;
	logic valid;
	logic ready;
	logic led_on;
	logic busy_now;
	logic start_accepted;

	modport source (output valid, led_on, busy_now, start_accepted, input ready);
	modport sink   (input valid, led_on, busy_now, start_accepted, output ready);
endinterface

[sv/led_blink_number_display.sv]
// led_blink_number_display: top level, slot timer, LED pattern and the
// microcoded digit extractor. Uses lbnd_pkg, lbnd_cmd_if and lbnd_rsp_if.
//
//   channel | dir | beat carries
//   --------+-----+------------------------------------------
//   cmd     | in  | opcode, value, once_flag
//   rsp     | out | led_on, busy_now, start_accepted
//   cfg     | in  | cfg_we + cfg_data (slot_ticks), no handshake
//
// Tick, enable, disable and an ignored start: result appears in the cycle after the beat.
// Accepted start: the sequencer steps EXP, LEAD and SEC, each looping while its compare
// holds, then FIN; one compare/subtract per step against a power-of-ten table.
// cmd takes a new beat once the sequencer is idle and the result register is free
// or draining in the same cycle; a stalled rsp holds its beat.
// arst_n clears all control state; slot_ticks resets to 200.

module led_blink_number_display #(
	parameter int PATTERN_SLOTS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	lbnd_cmd_if.sink    cmd,
	lbnd_rsp_if.source  rsp
);

	localparam int SW = $clog2(PATTERN_SLOTS);
	localparam logic [SW-1:0] SLOT_MAX = SW'(PATTERN_SLOTS - 1);

	// configuration
	logic [15:0] slot_ticks_q;

	// display state
	logic [15:0]   tick_q;
	logic [SW-1:0] slot_q;
	logic [3:0]    lead_q, sec_q, exp_q;
	logic [6:0]    len_q;
	logic          zero_q, once_q, busy_q, en_q, led_q;

	// sequencer and its datapath
	logic          run_q;
	lbnd_pkg::step_t pc_q;
	logic [31:0]   v_q;
	logic [3:0]    k_q, w_q, d_q;

	// result register
	logic rsp_valid_q, rsp_led_q, rsp_busy_q, rsp_acc_q;

	logic cmd_beat, rsp_free, rsp_load;
	lbnd_pkg::opcode_t op;

	assign op       = lbnd_pkg::opcode_t'(cmd.opcode);
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign cmd.ready = !run_q && rsp_free;
	assign cmd_beat  = cmd.valid && cmd.ready;

	assign rsp.valid          = rsp_valid_q;
	assign rsp.led_on         = rsp_led_q;
	assign rsp.busy_now       = rsp_busy_q;
	assign rsp.start_accepted = rsp_acc_q;

	// ---------------- slot timer step ----------------
	logic          wrap;
	logic [15:0]   tick_nx;
	logic [SW-1:0] slot_nx;

	assign wrap    = ({1'b0, tick_q} + 17'd1) >= {1'b0, slot_ticks_q};
	assign tick_nx = wrap ? 16'd0 : tick_q + 16'd1;
	assign slot_nx = (wrap && slot_q < SLOT_MAX) ? slot_q + SW'(1) : slot_q;

	// ---------------- pattern lookup at slot_nx ----------------
	logic [6:0] w2, d2, e2, a_lo, a_hi, b_lo, b_hi;
	logic       lit;

	assign w2   = {2'b00, lead_q, 1'b0};
	assign d2   = {2'b00, sec_q, 1'b0};
	assign e2   = {2'b00, exp_q, 1'b0};
	assign a_lo = w2 + 7'd2;
	assign a_hi = a_lo + d2;
	assign b_lo = w2 + d2 + 7'd4;
	assign b_hi = b_lo + e2;

	always_comb begin
		if (zero_q) begin
			lit = slot_nx < SW'(lbnd_pkg::ZERO_LIT_SLOTS);
		end else if (slot_nx[0]) begin
			lit = 1'b0;
		end else begin
			lit = (slot_nx < SW'(w2)) ||
			      (slot_nx >= SW'(a_lo) && slot_nx < SW'(a_hi)) ||
			      (slot_nx >= SW'(b_lo) && slot_nx < SW'(b_hi));
		end
	end

	// ---------------- microcode word and compare/subtract unit ----------------
	lbnd_pkg::uword_t uw;
	logic [3:0]  pidx;
	logic [31:0] pw;
	logic        ge, cond_true;

	assign uw = lbnd_pkg::ucode(pc_q);

	// result register is loaded by every beat except an accepted start, and by the
	// finish step
	assign rsp_load = (cmd_beat && !(op == lbnd_pkg::OP_START && !busy_q)) ||
	                  (run_q && uw.fin);

	always_comb begin
		unique case (uw.psel)
			lbnd_pkg::PS_KP1: pidx = k_q + 4'd1;
			lbnd_pkg::PS_K:   pidx = k_q;
			lbnd_pkg::PS_KM1: pidx = k_q - 4'd1;
			default:          pidx = k_q;
		endcase
	end

	assign pw = lbnd_pkg::pow10(pidx);
	assign ge = v_q >= pw;

	always_comb begin
		unique case (uw.cond)
			lbnd_pkg::COND_GE:      cond_true = ge;
			lbnd_pkg::COND_GE_KLT9: cond_true = ge && (k_q != lbnd_pkg::MAX_EXP);
			lbnd_pkg::COND_GE_KNZ:  cond_true = ge && (k_q != 4'd0);
			default:                cond_true = 1'b0;
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_ticks_q <= lbnd_pkg::SLOT_TICKS_RST;
		end else if (cfg_we) begin
			slot_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			slot_q      <= '0;
			lead_q      <= '0;
			sec_q       <= '0;
			exp_q       <= '0;
			len_q       <= '0;
			zero_q      <= 1'b0;
			once_q      <= 1'b0;
			busy_q      <= 1'b0;
			en_q        <= 1'b0;
			led_q       <= 1'b0;
			run_q       <= 1'b0;
			pc_q        <= lbnd_pkg::STEP_EXP;
			v_q         <= '0;
			k_q         <= '0;
			w_q         <= '0;
			d_q         <= '0;
			rsp_valid_q <= 1'b0;
			rsp_led_q   <= 1'b0;
			rsp_busy_q  <= 1'b0;
			rsp_acc_q   <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end

			if (cmd_beat) begin
				case (op)
					lbnd_pkg::OP_TICK: begin
						logic          led_nx, busy_nx;
						logic [15:0]   tick_n;
						logic [SW-1:0] slot_n;
						led_nx  = led_q;
						busy_nx = busy_q;
						tick_n  = tick_q;
						slot_n  = slot_q;
						if (len_q != 7'd0) begin
							tick_n = tick_nx;
							slot_n = slot_nx;
							if (en_q) begin
								led_nx = lit;
								if (slot_nx > SW'(len_q)) begin
									if (!once_q) begin
										tick_n = '0;
										slot_n = '0;
									end
									busy_nx = 1'b0;
								end
							end
						end
						tick_q      <= tick_n;
						slot_q      <= slot_n;
						led_q       <= led_nx;
						busy_q      <= busy_nx;
						rsp_valid_q <= 1'b1;
						rsp_led_q   <= led_nx;
						rsp_busy_q  <= busy_nx;
						rsp_acc_q   <= 1'b0;
					end
					lbnd_pkg::OP_START: begin
						if (busy_q) begin
							rsp_valid_q <= 1'b1;
							rsp_led_q   <= led_q;
							rsp_busy_q  <= 1'b1;
							rsp_acc_q   <= 1'b0;
						end else begin
							// result comes from the finish step
							busy_q <= 1'b1;
							en_q   <= 1'b1;
							once_q <= cmd.once_flag;
							tick_q <= '0;
							slot_q <= '0;
							run_q  <= 1'b1;
							pc_q   <= lbnd_pkg::STEP_EXP;
							v_q    <= cmd.value;
							k_q    <= '0;
							w_q    <= '0;
							d_q    <= '0;
						end
					end
					lbnd_pkg::OP_ENABLE: begin
						en_q        <= 1'b1;
						rsp_valid_q <= 1'b1;
						rsp_led_q   <= led_q;
						rsp_busy_q  <= busy_q;
						rsp_acc_q   <= 1'b0;
					end
					default: begin
						en_q        <= 1'b0;
						rsp_valid_q <= 1'b1;
						rsp_led_q   <= led_q;
						rsp_busy_q  <= busy_q;
						rsp_acc_q   <= 1'b0;
					end
				endcase
			end

			if (run_q) begin
				if (uw.fin) begin
					// zero input leaves the lead count at zero
					lead_q <= w_q;
					sec_q  <= d_q;
					exp_q  <= k_q;
					zero_q <= (w_q == 4'd0);
					len_q  <= (w_q == 4'd0) ? lbnd_pkg::ZERO_LEN :
					          {2'b00, w_q, 1'b0} + {2'b00, d_q, 1'b0} +
					          {2'b00, k_q, 1'b0} + lbnd_pkg::TAIL_SLOTS;
					run_q  <= 1'b0;
					pc_q   <= uw.t_next;
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_led_q   <= led_q;
						rsp_busy_q  <= 1'b1;
						rsp_acc_q   <= 1'b1;
					end
				end else if (cond_true) begin
					pc_q <= uw.t_next;
					case (uw.act)
						lbnd_pkg::ACT_INC_K: k_q <= k_q + 4'd1;
						lbnd_pkg::ACT_CNT_W: begin
							v_q <= v_q - pw;
							w_q <= w_q + 4'd1;
						end
						lbnd_pkg::ACT_CNT_D: begin
							v_q <= v_q - pw;
							d_q <= d_q + 4'd1;
						end
						default: ;
					endcase
				end else begin
					pc_q <= uw.f_next;
				end
			end
		end
	end

	// the finish step must not retire while the result register is full
	// (it only gets there after a beat that found the register free)

`ifndef SYNTHESIS
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.start_accepted |-> rsp.busy_now)
		else $error("accepted start reported without busy");

	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> k_q <= lbnd_pkg::MAX_EXP)
		else $error("exponent counter out of range");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= lbnd_pkg::MAX_LEN)
		else $error("pattern length out of range");

	a_idle_pc: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> pc_q == lbnd_pkg::STEP_EXP)
		else $error("sequencer left mid-program");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && uw.fin |-> rsp_free)
		else $error("finish step with result register full");
`endif

endmodule
